[design/qrr_pkg.sv]
// ----------------------------------------------------------------------------
// qrr_pkg
// Shared types and constants for the quadratic real roots pipeline.
// ----------------------------------------------------------------------------
package qrr_pkg;

	localparam int ROOT_W = 34;

	typedef enum logic [1:0] {
		ST_REAL  = 2'd0,
		ST_NONE  = 2'd1,
		ST_AZERO = 2'd2,
		ST_OVF   = 2'd3
	} status_t;

endpackage

[design/quadratic_real_roots.sv]
// ----------------------------------------------------------------------------
// quadratic_real_roots
// Real roots of a*x^2 + b*x + c in signed fixed point, fully pipelined.
//
// Usage: drive coef_a, coef_b, coef_c and pulse start; an item is taken at
// every edge with start high (busy is always low, so one item per cycle).
// Each item gives one result: root_plus, root_minus and status are valid for
// the single cycle in which done is high. Items leave in order.
// Stages: product, discriminant, one square-root bit per stage, numerator,
// one quotient bit per stage (two dividers side by side), sign and range.
// Status: 0 real roots, 1 no real roots, 2 a is zero, 3 root overflow; roots
// read zero unless status is 0. Roots are Q17.16 truncated toward zero.
// Reset clears every valid bit; items in flight are dropped. The receiver
// cannot stall: a result is shown once and must be taken in that cycle.
// ----------------------------------------------------------------------------
module quadratic_real_roots
	import qrr_pkg::*;
#(
	parameter int COEF_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [COEF_BITS-1:0] coef_a,
	input  logic signed [COEF_BITS-1:0] coef_b,
	input  logic signed [COEF_BITS-1:0] coef_c,
	output logic                        done,
	output logic signed [ROOT_W-1:0]    root_plus,
	output logic signed [ROOT_W-1:0]    root_minus,
	output logic [1:0]                  status
);

	localparam int C    = COEF_BITS;
	localparam int F    = FRAC_BITS;
	localparam int DXW  = 2 * C + 2;
	localparam int RW   = C + F + 1;
	localparam int RADW = 2 * RW;
	localparam int RMW  = RW + 2;
	localparam int NW   = C + F + 3;
	localparam int MW   = NW - 1;
	localparam int DW   = C + 1;
	localparam int XW   = ((MW + 1) > ROOT_W ? (MW + 1) : ROOT_W) + 1;
	localparam int LAT  = 3 + RW + MW + 1;
	localparam logic signed [XW-1:0] LIM_HI = (XW'(1) <<< (ROOT_W - 1)) - XW'(1);
	localparam logic signed [XW-1:0] LIM_LO = -LIM_HI - XW'(1);

	assign busy = 1'b0;

	// products
	logic                 v_s1;
	logic signed [2*C-1:0] bb_s1, ac_s1;
	logic signed [C-1:0]  a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		bb_s1 <= coef_b * coef_b;
		ac_s1 <= coef_a * coef_c;
		a_s1  <= coef_a;
		b_s1  <= coef_b;
	end

	// discriminant, numerator base, divisor magnitude
	logic signed [DXW-1:0] disc;
	logic signed [C:0]     a_x, a_m;

	assign disc = DXW'(bb_s1) - (DXW'(ac_s1) <<< 2);
	assign a_x  = (C+1)'(a_s1);
	assign a_m  = a_s1[C-1] ? -a_x : a_x;

	logic                  sqv_s   [RW+1];
	logic [RMW-1:0]        sqrem_s [RW+1];
	logic [RW-1:0]         sqrt_s  [RW+1];
	logic [RADW-1:0]       sqrad_s [RW+1];
	logic signed [NW-1:0]  sqbase_s[RW+1];
	logic [DW-1:0]         sqden_s [RW+1];
	logic                  sqdneg_s[RW+1];
	status_t               sqst_s  [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s[0] <= 1'b0;
		end else begin
			sqv_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqrem_s[0]  <= '0;
		sqrt_s[0]   <= '0;
		sqrad_s[0]  <= RADW'(disc[2*C:0]) << (2 * F);
		sqbase_s[0] <= (-(NW'(b_s1))) <<< F;
		sqden_s[0]  <= DW'(a_m) << 1;
		sqdneg_s[0] <= a_s1[C-1];
		if (a_s1 == '0) begin
			sqst_s[0] <= ST_AZERO;
		end else if (disc[DXW-1]) begin
			sqst_s[0] <= ST_NONE;
		end else begin
			sqst_s[0] <= ST_REAL;
		end
	end

	// square root, one bit per stage
	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [RMW+1:0] rem_n, trial, diff;
		logic           ge;

		assign rem_n = {sqrem_s[j], sqrad_s[j][RADW-1 -: 2]};
		assign trial = (RMW+2)'({sqrt_s[j], 2'b01});
		assign diff  = rem_n - trial;
		assign ge    = rem_n >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[j+1] <= 1'b0;
			end else begin
				sqv_s[j+1] <= sqv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sqrem_s[j+1]  <= ge ? diff[RMW-1:0] : rem_n[RMW-1:0];
			sqrt_s[j+1]   <= {sqrt_s[j][RW-2:0], ge};
			sqrad_s[j+1]  <= sqrad_s[j] << 2;
			sqbase_s[j+1] <= sqbase_s[j];
			sqden_s[j+1]  <= sqden_s[j];
			sqdneg_s[j+1] <= sqdneg_s[j];
			sqst_s[j+1]   <= sqst_s[j];
		end
	end

	// numerators; lane 0 is the plus root, lane 1 the minus root
	logic signed [NW-1:0] num_p, num_m;

	assign num_p = sqbase_s[RW] + $signed(NW'(sqrt_s[RW]));
	assign num_m = sqbase_s[RW] - $signed(NW'(sqrt_s[RW]));

	logic          dvv_s  [MW+1];
	logic [MW-1:0] dvnum_s[2][MW+1];
	logic [MW-1:0] dvq_s  [2][MW+1];
	logic [DW-1:0] dvrem_s[2][MW+1];
	logic          dvneg_s[2][MW+1];
	logic [DW-1:0] dvden_s[MW+1];
	status_t       dvst_s [MW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv_s[0] <= 1'b0;
		end else begin
			dvv_s[0] <= sqv_s[RW];
		end
	end

	always_ff @(posedge clk) begin
		dvnum_s[0][0] <= num_p[NW-1] ? MW'(-num_p) : MW'(num_p);
		dvnum_s[1][0] <= num_m[NW-1] ? MW'(-num_m) : MW'(num_m);
		dvneg_s[0][0] <= num_p[NW-1] ^ sqdneg_s[RW];
		dvneg_s[1][0] <= num_m[NW-1] ^ sqdneg_s[RW];
		dvq_s[0][0]   <= '0;
		dvq_s[1][0]   <= '0;
		dvrem_s[0][0] <= '0;
		dvrem_s[1][0] <= '0;
		dvden_s[0]    <= sqden_s[RW];
		dvst_s[0]     <= sqst_s[RW];
	end

	// restoring divide, one quotient bit per stage
	for (genvar k = 0; k < MW; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[k+1] <= 1'b0;
			end else begin
				dvv_s[k+1] <= dvv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dvden_s[k+1] <= dvden_s[k];
			dvst_s[k+1]  <= dvst_s[k];
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [DW:0] rs, rd;
			logic        ge;

			assign rs = {dvrem_s[l][k], dvnum_s[l][k][MW-1]};
			assign rd = rs - {1'b0, dvden_s[k]};
			assign ge = rs >= {1'b0, dvden_s[k]};

			always_ff @(posedge clk) begin
				dvrem_s[l][k+1] <= ge ? rd[DW-1:0] : rs[DW-1:0];
				dvq_s[l][k+1]   <= {dvq_s[l][k][MW-2:0], ge};
				dvnum_s[l][k+1] <= dvnum_s[l][k] << 1;
				dvneg_s[l][k+1] <= dvneg_s[l][k];
			end
		end
	end

	// sign, range check, output register
	logic signed [XW-1:0] qx_p, qx_m, rp, rm;
	logic                 ovf;

	assign qx_p = $signed(XW'(dvq_s[0][MW]));
	assign qx_m = $signed(XW'(dvq_s[1][MW]));
	assign rp   = dvneg_s[0][MW] ? -qx_p : qx_p;
	assign rm   = dvneg_s[1][MW] ? -qx_m : qx_m;
	assign ovf  = (rp > LIM_HI) || (rp < LIM_LO) || (rm > LIM_HI) || (rm < LIM_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvv_s[MW];
		end
	end

	always_ff @(posedge clk) begin
		if (dvst_s[MW] == ST_REAL && !ovf) begin
			root_plus  <= rp[ROOT_W-1:0];
			root_minus <= rm[ROOT_W-1:0];
			status     <= ST_REAL;
		end else begin
			root_plus  <= '0;
			root_minus <= '0;
			status     <= (dvst_s[MW] == ST_REAL) ? ST_OVF : dvst_s[MW];
		end
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching item");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		dvv_s[MW] |=> done)
		else $error("item lost at output stage");

	a_zero_roots: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_REAL) |-> (root_plus == '0 && root_minus == '0))
		else $error("nonzero roots with failure status");

	a_sqrt_order: assert property (@(posedge clk) disable iff (!arst_n)
		sqv_s[0] |-> $past(v_s1))
		else $error("valid bit out of step in discriminant stage");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives coefficient sets into quadratic_real_roots with random gaps, predicts
// roots and status per item, and checks each done strobe in order.
// ----------------------------------------------------------------------------
module tb_top;
	import qrr_pkg::*;

	localparam int CB = 16;
	localparam int FB = 16;
	localparam int LAT = 71;
	localparam int WD_LIMIT = 5000;

	typedef struct {
		logic signed [ROOT_W-1:0] rp;
		logic signed [ROOT_W-1:0] rm;
		status_t st;
	} roots_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [CB-1:0] coef_a = '0, coef_b = '0, coef_c = '0;
	logic done;
	logic signed [ROOT_W-1:0] root_plus, root_minus;
	logic [1:0] status;

	roots_t roots_q[$];
	int fails = 0;
	int idle_cnt = 0;

	quadratic_real_roots u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint unsigned isqrt_fixed(longint unsigned d);
		longint unsigned rem, root, trial, pair;
		rem = 0;
		root = 0;
		for (int i = 31; i >= -FB; i--) begin
			pair = (i >= 0) ? ((d >> (2 * i)) & 3) : 0;
			rem = (rem << 2) | pair;
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic roots_t solve_roots(logic signed [CB-1:0] a, logic signed [CB-1:0] b,
			logic signed [CB-1:0] c);
		roots_t r;
		longint disc, s, base, den, p, m, hi, lo;
		hi = (64'sd1 <<< (ROOT_W - 1)) - 1;
		lo = -hi - 1;
		r.rp = '0;
		r.rm = '0;
		if (a == 0) begin
			r.st = ST_AZERO;
			return r;
		end
		disc = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
		if (disc < 0) begin
			r.st = ST_NONE;
			return r;
		end
		s = longint'(isqrt_fixed(disc));
		base = -longint'(b) * (64'sd1 <<< FB);
		den = 2 * longint'(a);
		p = (base + s) / den;
		m = (base - s) / den;
		if (p > hi || p < lo || m > hi || m < lo) begin
			r.st = ST_OVF;
			return r;
		end
		r.rp = p[ROOT_W-1:0];
		r.rm = m[ROOT_W-1:0];
		r.st = ST_REAL;
		return r;
	endfunction

	always @(posedge clk) begin
		if (done) begin
			if (roots_q.size() == 0) begin
				$error("unexpected result");
				fails++;
			end else begin
				roots_t e;
				e = roots_q.pop_front();
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					fails++;
				end
				if (root_plus !== e.rp) begin
					$error("root_plus exp %0d got %0d", e.rp, root_plus);
					fails++;
				end
				if (root_minus !== e.rm) begin
					$error("root_minus exp %0d got %0d", e.rm, root_minus);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WD_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_coefs(logic signed [CB-1:0] a, logic signed [CB-1:0] b,
			logic signed [CB-1:0] c);
		gap();
		start <= 1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		do @(posedge clk); while (busy);
		roots_q.push_back(solve_roots(a, b, c));
	endtask

	task automatic test_directed();
		send_coefs(0, 5, 3);
		send_coefs(0, 0, 0);
		send_coefs(1, 0, 1);
		send_coefs(1, -3, 2);
		send_coefs(1, 2, 1);
		send_coefs(-1, 0, 4);
		send_coefs(32767, 32767, 32767);
		send_coefs(-32768, -32768, -32768);
		send_coefs(-32768, 32767, 32767);
		send_coefs(32767, -32768, -32768);
		send_coefs(1, -32768, 0);
		send_coefs(1, 32767, -32768);
		send_coefs(-1, -32768, 32767);
		send_coefs(1, 0, -32768);
		send_coefs(2, 1, 0);
		send_coefs(-3, 7, 5);
	endtask

	task automatic test_random();
		logic signed [CB-1:0] a, b, c;
		for (int i = 0; i < 1800; i++) begin
			a = CB'($urandom);
			b = CB'($urandom);
			c = CB'($urandom);
			case ($urandom_range(0, 5))
				0: a = CB'($urandom_range(0, 6) - 3);
				1: c = -(a >>> $urandom_range(0, 15));
				2: begin
					a = CB'($urandom_range(0, 64) - 32);
					c = CB'($urandom_range(0, 64) - 32);
				end
				default: ;
			endcase
			send_coefs(a, b, c);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random();
		start <= 0;
		wait (roots_q.size() == 0);
		repeat (LAT + 10) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
